@@ hw/rtl/bfba_pkg.sv @@
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared sizes, request codes and the microcode table of the best-fit
// block allocator.
// ----------------------------------------------------------------------------
package bfba_pkg;

    // table geometry
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    // fixed port widths
    localparam int KIND_W  = 2;
    localparam int BIDX_W  = 4;
    localparam int SIZE_W  = 16;
    localparam int BCNT_W  = 5;
    localparam int WASTE_W = 20;
    localparam int SUM_W   = ((WASTE_W > SIZE_BITS) ? WASTE_W : SIZE_BITS) + 1;

    localparam logic [WASTE_W-1:0] WASTE_MAX   = '1;
    localparam logic [BCNT_W-1:0]  BCNT_RESET  = BCNT_W'(MAX_BLOCKS);

    // request codes
    localparam logic [KIND_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_ALLOC  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_REPORT = 2'd2;

    // datapath operations
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_LATCH  = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd4;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd5;
    localparam logic [OP_W-1:0] OP_POST   = 3'd6;

    // jump conditions; a false condition holds the step
    localparam int COND_W = 2;
    localparam logic [COND_W-1:0] C_ALWAYS   = 2'd0;
    localparam logic [COND_W-1:0] C_DISPATCH = 2'd1;
    localparam logic [COND_W-1:0] C_SCAN_END = 2'd2;
    localparam logic [COND_W-1:0] C_OUT_FREE = 2'd3;

    // microcode addresses
    localparam int UC_W = 3;
    localparam logic [UC_W-1:0] UC_IDLE   = 3'd0;
    localparam logic [UC_W-1:0] UC_LOAD   = 3'd1;
    localparam logic [UC_W-1:0] UC_INIT   = 3'd2;
    localparam logic [UC_W-1:0] UC_SCAN   = 3'd3;
    localparam logic [UC_W-1:0] UC_COMMIT = 3'd4;
    localparam logic [UC_W-1:0] UC_POST   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [UC_W-1:0]   target;
    } uword_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic              accept;
        logic [KIND_W-1:0] kind;
        logic              scan_end;
        logic              out_free;
    } useq_stat_t;

    // control from sequencer to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            idle;
    } useq_ctrl_t;

    function automatic uword_t uc_rom(input logic [UC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: UC_IDLE};
        case (addr)
            UC_IDLE:   w = '{op: OP_LATCH,  cond: C_DISPATCH, target: UC_IDLE};
            UC_LOAD:   w = '{op: OP_LOAD,   cond: C_ALWAYS,   target: UC_POST};
            UC_INIT:   w = '{op: OP_INIT,   cond: C_ALWAYS,   target: UC_SCAN};
            UC_SCAN:   w = '{op: OP_SCAN,   cond: C_SCAN_END, target: UC_COMMIT};
            UC_COMMIT: w = '{op: OP_COMMIT, cond: C_ALWAYS,   target: UC_POST};
            UC_POST:   w = '{op: OP_POST,   cond: C_OUT_FREE, target: UC_IDLE};
            default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: UC_IDLE};
        endcase
        return w;
    endfunction

    // entry point of the routine for each request type
    function automatic logic [UC_W-1:0] uc_dispatch(input logic [KIND_W-1:0] kind);
        logic [UC_W-1:0] a;
        a = UC_POST;
        case (kind)
            REQ_LOAD:   a = UC_LOAD;
            REQ_ALLOC:  a = UC_INIT;
            REQ_REPORT: a = UC_INIT;
            default:    a = UC_POST;
        endcase
        return a;
    endfunction

endpackage

@@ hw/rtl/bfba_useq.sv @@
// ----------------------------------------------------------------------------
// bfba_useq
// Microcode sequencer: step counter, control table lookup and jumps.
// ----------------------------------------------------------------------------
module bfba_useq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bfba_pkg::useq_stat_t  stat,
    output bfba_pkg::useq_ctrl_t  ctrl
);
    import bfba_pkg::*;

    logic [UC_W-1:0] upc_reg;
    logic [UC_W-1:0] upc_next;
    uword_t          word;

    assign word = uc_rom(upc_reg);

    always_comb
    begin
        upc_next = upc_reg;
        case (word.cond)
            C_ALWAYS:   upc_next = word.target;
            C_DISPATCH:
            begin
                if (stat.accept)
                begin
                    upc_next = uc_dispatch(stat.kind);
                end
            end
            C_SCAN_END:
            begin
                if (stat.scan_end)
                begin
                    upc_next = word.target;
                end
            end
            C_OUT_FREE:
            begin
                if (stat.out_free)
                begin
                    upc_next = word.target;
                end
            end
            default:    upc_next = UC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.idle = (upc_reg == UC_IDLE);

endmodule

@@ hw/rtl/best_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit allocator over a table of block sizes with taken flags, driven
// by a microcoded sequencer and a one-entry-per-cycle scan datapath.
// ----------------------------------------------------------------------------
//  channel   signals                                          direction
//  input     in_valid/in_ready, req_type, block_index,        in
//            size_value
//  output    out_valid/out_ready, result_kind, granted,       out
//            chosen_block, leftover, total_waste, free_blocks
//  config    cfg_we, cfg_wdata (block_count)                  in
//
//  after acceptance a load runs the load and post steps, an unknown type
//  only the post step, allocate and report the init, scan, commit and post
//  steps; the scan reads one entry per cycle over the blocks in use
//  the result is valid once the sequencer is back in its idle step
//  the output register holds a result while the next transaction is taken
//  reset clears taken flags, waste total and block_count (to 16), no sweep
//  a stalled output holds the sequencer in its final step
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bfba_pkg::BCNT_W-1:0]    cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bfba_pkg::KIND_W-1:0]    req_type,
    input  logic [bfba_pkg::BIDX_W-1:0]    block_index,
    input  logic [bfba_pkg::SIZE_W-1:0]    size_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bfba_pkg::KIND_W-1:0]    result_kind,
    output logic                           granted,
    output logic [bfba_pkg::BIDX_W-1:0]    chosen_block,
    output logic [bfba_pkg::SIZE_W-1:0]    leftover,
    output logic [bfba_pkg::WASTE_W-1:0]   total_waste,
    output logic [bfba_pkg::BCNT_W-1:0]    free_blocks
);
    import bfba_pkg::*;

    useq_stat_t stat;
    useq_ctrl_t ctrl;

    // latched request
    logic [KIND_W-1:0]    kind_reg;
    logic [BIDX_W-1:0]    bidx_reg;
    logic [SIZE_BITS-1:0] size_reg;

    // block table and flags
    logic [SIZE_BITS-1:0]  block_size_reg [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] taken_reg, taken_next;
    logic [WASTE_W-1:0]    waste_reg, waste_next;
    logic [BCNT_W-1:0]     count_reg, count_next;

    // scan state
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [SIZE_BITS-1:0] best_left_reg, best_left_next;
    logic [WASTE_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    out_kind_reg;
    logic                 out_granted_reg;
    logic [BIDX_W-1:0]    out_chosen_reg;
    logic [SIZE_W-1:0]    out_left_reg;
    logic [WASTE_W-1:0]   out_total_reg;
    logic [BCNT_W-1:0]    out_free_reg;

    logic                 accept;
    logic                 out_free;
    logic [CNT_W-1:0]     n_eff;
    logic                 scan_end;
    logic [IDX_W-1:0]     scan_idx;
    logic [SIZE_BITS-1:0] cur_size;
    logic                 cur_taken;
    logic                 fits;
    logic [SIZE_BITS-1:0] cur_left;
    logic [SUM_W-1:0]     rep_sum;
    logic [SUM_W-1:0]     alloc_sum;
    logic                 load_ok;
    logic                 res_granted;

    bfba_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign in_ready = ctrl.idle;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign n_eff    = (int'(count_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(count_reg);
    assign scan_end = (idx_reg >= n_eff);
    assign scan_idx = idx_reg[IDX_W-1:0];

    assign cur_size  = block_size_reg[scan_idx];
    assign cur_taken = taken_reg[scan_idx];
    assign fits      = !cur_taken && (size_reg <= cur_size);
    assign cur_left  = cur_size - size_reg;
    assign rep_sum   = SUM_W'(acc_reg) + SUM_W'(cur_size);
    assign alloc_sum = SUM_W'(waste_reg) + SUM_W'(best_left_reg);
    assign load_ok   = (int'(bidx_reg) < MAX_BLOCKS);

    assign res_granted = (kind_reg == REQ_ALLOC) && found_reg;

    assign stat.accept   = accept;
    assign stat.kind     = req_type;
    assign stat.scan_end = scan_end;
    assign stat.out_free = out_free;

    always_comb
    begin
        taken_next     = taken_reg;
        waste_next     = waste_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_left_next = best_left_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            count_next = cfg_wdata;
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                if (load_ok)
                begin
                    taken_next[bidx_reg[IDX_W-1:0]] = 1'b0;
                end
            end
            OP_INIT:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                acc_next   = waste_reg;
                cnt_next   = '0;
            end
            OP_SCAN:
            begin
                if (!scan_end)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (kind_reg == REQ_ALLOC)
                    begin
                        if (fits && (!found_reg || (cur_left < best_left_reg)))
                        begin
                            found_next     = 1'b1;
                            best_next      = scan_idx;
                            best_left_next = cur_left;
                        end
                    end
                    else if (!cur_taken)
                    begin
                        // report: saturating sum of the waste total and the free sizes
                        acc_next = (rep_sum > SUM_W'(WASTE_MAX)) ? WASTE_MAX
                                                                 : rep_sum[WASTE_W-1:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            OP_COMMIT:
            begin
                if (res_granted)
                begin
                    taken_next[best_reg] = 1'b1;
                    waste_next = (alloc_sum > SUM_W'(WASTE_MAX)) ? WASTE_MAX
                                                                 : alloc_sum[WASTE_W-1:0];
                end
            end
            OP_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg     <= '0;
            waste_reg     <= '0;
            count_reg     <= BCNT_RESET;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            taken_reg     <= taken_next;
            waste_reg     <= waste_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg      <= best_next;
        best_left_reg <= best_left_next;
        if (accept)
        begin
            kind_reg <= req_type;
            bidx_reg <= block_index;
            size_reg <= SIZE_BITS'(size_value);
        end
        if (ctrl.op == OP_LOAD && load_ok)
        begin
            block_size_reg[bidx_reg[IDX_W-1:0]] <= size_reg;
        end
        if (ctrl.op == OP_POST && out_free)
        begin
            out_kind_reg    <= kind_reg;
            out_granted_reg <= res_granted;
            out_chosen_reg  <= res_granted ? BIDX_W'(best_reg) : '0;
            out_left_reg    <= res_granted ? SIZE_W'(best_left_reg) : '0;
            case (kind_reg)
                REQ_LOAD:   out_total_reg <= waste_reg;
                REQ_ALLOC:  out_total_reg <= waste_reg;
                REQ_REPORT: out_total_reg <= acc_reg;
                default:    out_total_reg <= '0;
            endcase
            out_free_reg <= (kind_reg == REQ_REPORT) ? BCNT_W'(cnt_reg) : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign granted      = out_granted_reg;
    assign chosen_block = out_chosen_reg;
    assign leftover     = out_left_reg;
    assign total_waste  = out_total_reg;
    assign free_blocks  = out_free_reg;

    // a result only appears after the final microcode step
    a_post_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == OP_POST))
        else $error("result raised outside the post step");

    // a grant only answers an allocate transaction
    a_grant_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_granted_reg |-> out_kind_reg == REQ_ALLOC)
        else $error("grant on a non-allocate result");

    // scan index never runs past the blocks in use
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_SCAN |-> idx_reg <= n_eff)
        else $error("scan index beyond block count");

    // an accepted transaction always leaves the idle step
    a_accept_leave: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !ctrl.idle)
        else $error("sequencer stayed idle after acceptance");

    // free count never exceeds the table size
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> int'(out_free_reg) <= MAX_BLOCKS)
        else $error("free block count out of range");

endmodule
